FILE: rtl/glm_pkg.sv
// shared types, codes and defaults of the group biased lock manager
package glm_pkg;

  localparam int LOCK_SLOTS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [6:0] FAVOR_MAX = 7'd100;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_FAVOR  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NO_LOCK    = 3'd3,
    ST_NOT_OWNER  = 3'd4,
    ST_BUSY       = 3'd5,
    ST_QUEUE_FULL = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ADDR_POS,
    ADDR_SHIFT,
    ADDR_HEAD
  } addr_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SRD,
    S_SCHK,
    S_MRD,
    S_MWR,
    S_HRD,
    S_HWT,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      scan;
    logic      exec;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      pos_inc;
    logic      shift_load;
    logic      shift_dec;
    logic      shift_wr;
    logic      take_owner;
    logic      fin;
    logic      finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_create;
    logic hit;
    logic last;
    logic go_search;
    logic go_head;
    logic grp_match;
    logic pos_zero;
    logic pos_last;
    logic shift_zero;
  } dp_stat_t;

endpackage

FILE: rtl/glm_ctrl.sv
// sequencing state machine of the lock manager
module glm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  glm_pkg::dp_stat_t stat,
  output glm_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import glm_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = ADDR_POS;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.bad_create) begin
          state_next = S_EXEC;
        end else begin
          cmd.scan = 1'b1;
          if (stat.hit || stat.last) state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.go_search) begin
          state_next = S_SRD;
        end else if (stat.go_head) begin
          state_next = S_HRD;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_POS;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        priority if (stat.grp_match) begin
          cmd.take_owner = 1'b1;
          if (stat.pos_zero) begin
            state_next = S_FIN;
          end else begin
            cmd.shift_load = 1'b1;
            state_next     = S_MRD;
          end
        end else if (stat.pos_last) begin
          state_next = S_HRD;
        end else begin
          cmd.pos_inc = 1'b1;
          state_next  = S_SRD;
        end
      end
      S_MRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_SHIFT;
        state_next = S_MWR;
      end
      S_MWR: begin
        cmd.shift_wr = 1'b1;
        if (stat.shift_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.shift_dec = 1'b1;
          state_next    = S_MRD;
        end
      end
      S_HRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_HEAD;
        state_next = S_HWT;
      end
      S_HWT: begin
        cmd.take_owner = 1'b1;
        state_next     = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/glm_dp.sv
// slot table, waiter memory and result registers of the lock manager
module glm_dp #(
  parameter int LOCK_SLOTS  = glm_pkg::LOCK_SLOTS_DEF,
  parameter int QUEUE_DEPTH = glm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  glm_pkg::dp_cmd_t cmd,
  output glm_pkg::dp_stat_t stat,
  input  logic [1:0]       command,
  input  logic [31:0]      lock_id,
  input  logic [31:0]      new_id,
  input  logic [6:0]       favoritism_request,
  input  logic [15:0]      requester,
  input  logic [7:0]       requester_group,
  input  logic [6:0]       random_percent,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      created_id,
  output logic             granted_now,
  output logic             handoff_valid,
  output logic [15:0]      handoff_owner
);
  import glm_pkg::*;

  localparam int SW    = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = LOCK_SLOTS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [SW-1:0] SLOT_LAST = SW'(LOCK_SLOTS - 1);
  localparam logic [CW-1:0] QD_C      = CW'(QUEUE_DEPTH);
  localparam logic [QW:0]   QD_R      = (QW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] QD_A      = AW'(QUEUE_DEPTH);

  // ring position of a logical queue place
  function automatic logic [QW-1:0] ring(input logic [QW-1:0] hd, input logic [QW-1:0] ps);
    logic [QW:0] sum;
    sum = {1'b0, hd} + {1'b0, ps};
    if (sum >= QD_R) sum = sum - QD_R;
    return sum[QW-1:0];
  endfunction

  // slot table
  logic          used  [LOCK_SLOTS];
  logic [31:0]   ident [LOCK_SLOTS];
  logic          held  [LOCK_SLOTS];
  logic [6:0]    favor [LOCK_SLOTS];
  logic [15:0]   owner [LOCK_SLOTS];
  logic [QW-1:0] head  [LOCK_SLOTS];
  logic [CW-1:0] count [LOCK_SLOTS];

  // waiter memory
  logic [15:0] wproc [DEPTH];
  logic [7:0]  wgrp  [DEPTH];
  logic [15:0] rd_proc;
  logic [7:0]  rd_grp;

  // latched transaction
  cmd_t        cmd_r;
  logic [31:0] lid_r;
  logic [31:0] nid_r;
  logic [6:0]  fav_r;
  logic [15:0] req_r;
  logic [7:0]  grp_r;
  logic [6:0]  rnd_r;

  logic [SW-1:0] idx;
  logic [SW-1:0] sel;
  logic          found;
  logic [QW-1:0] pos;
  logic [QW-1:0] shift;
  logic [15:0]   own;

  logic          hit;
  logic          rel_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_proc;
  logic [7:0]    wr_grp;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] sel_base;
  logic [QW-1:0] rd_pos;

  // slot compare for the scan
  always_comb begin
    if (cmd_r == CMD_CREATE) hit = !used[idx];
    else                     hit = used[idx] && (ident[idx] == lid_r);
  end

  assign rel_ok = (cmd_r == CMD_RELEASE) && found && held[sel] &&
                  (owner[sel] == req_r) && (count[sel] != '0);

  assign stat.bad_create = (cmd_r == CMD_CREATE) && (fav_r > FAVOR_MAX);
  assign stat.hit        = hit;
  assign stat.last       = (idx == SLOT_LAST);
  assign stat.go_search  = rel_ok && (rnd_r < favor[sel]);
  assign stat.go_head    = rel_ok && !(rnd_r < favor[sel]);
  assign stat.grp_match  = (rd_grp == grp_r);
  assign stat.pos_zero   = (pos == '0);
  assign stat.pos_last   = ((CW'(pos) + CW'(1)) == count[sel]);
  assign stat.shift_zero = (shift == '0);

  // memory addressing
  assign sel_base = AW'(sel) * QD_A;

  always_comb begin
    unique case (cmd.rd_sel)
      ADDR_POS:   rd_pos = pos;
      ADDR_SHIFT: rd_pos = shift;
      ADDR_HEAD:  rd_pos = '0;
      default:    rd_pos = '0;
    endcase
  end

  assign rd_addr = sel_base + AW'(ring(head[sel], rd_pos));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sel_base + AW'(ring(head[sel], shift + QW'(1)));
    wr_proc = rd_proc;
    wr_grp  = rd_grp;
    if (cmd.shift_wr) begin
      wr_en = 1'b1;
    end else if (cmd.exec && (cmd_r == CMD_ACQUIRE) && found && held[sel] &&
                 (count[sel] != QD_C)) begin
      wr_en   = 1'b1;
      wr_addr = sel_base + AW'(ring(head[sel], count[sel][QW-1:0]));
      wr_proc = req_r;
      wr_grp  = grp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wproc[wr_addr] <= wr_proc;
      wgrp[wr_addr]  <= wr_grp;
    end
    if (cmd.rd_en) begin
      rd_proc <= wproc[rd_addr];
      rd_grp  <= wgrp[rd_addr];
    end
  end

  // transaction latch, scan and queue pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= cmd_t'(command);
      lid_r <= lock_id;
      nid_r <= new_id;
      fav_r <= favoritism_request;
      req_r <= requester;
      grp_r <= requester_group;
      rnd_r <= random_percent;
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      if (hit) begin
        sel   <= idx;
        found <= 1'b1;
      end else begin
        idx <= idx + SW'(1);
      end
    end
    if (cmd.exec)           pos   <= '0;
    else if (cmd.pos_inc)   pos   <= pos + QW'(1);
    if (cmd.shift_load)     shift <= pos - QW'(1);
    else if (cmd.shift_dec) shift <= shift - QW'(1);
    if (cmd.take_owner)     own   <= rd_proc;
  end

  // slot table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOCK_SLOTS; i++) begin
        used[i]  <= 1'b0;
        ident[i] <= '0;
        held[i]  <= 1'b0;
        favor[i] <= '0;
        owner[i] <= '0;
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else if (cmd.exec && found) begin
      unique case (cmd_r)
        CMD_CREATE: begin
          if (!stat.bad_create) begin
            used[sel]  <= 1'b1;
            ident[sel] <= nid_r;
            held[sel]  <= 1'b0;
            favor[sel] <= fav_r;
            owner[sel] <= '0;
            head[sel]  <= '0;
            count[sel] <= '0;
          end
        end
        CMD_ACQUIRE: begin
          if (!held[sel]) begin
            held[sel]  <= 1'b1;
            owner[sel] <= req_r;
          end else if (count[sel] != QD_C) begin
            count[sel] <= count[sel] + CW'(1);
          end
        end
        CMD_RELEASE: begin
          if (held[sel] && (owner[sel] == req_r)) begin
            held[sel]  <= 1'b0;
            owner[sel] <= '0;
          end
        end
        CMD_DESTROY: begin
          if (!held[sel] && (count[sel] == '0)) begin
            used[sel]  <= 1'b0;
            ident[sel] <= '0;
            favor[sel] <= '0;
            owner[sel] <= '0;
            head[sel]  <= '0;
            count[sel] <= '0;
          end
        end
        default: ;
      endcase
    end else if (cmd.fin) begin
      head[sel]  <= ring(head[sel], QW'(1));
      count[sel] <= count[sel] - CW'(1);
      held[sel]  <= 1'b1;
      owner[sel] <= own;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      created_id    <= '0;
      granted_now   <= 1'b0;
      handoff_valid <= 1'b0;
      handoff_owner <= '0;
      status        <= ST_OK;
      priority if (stat.bad_create) begin
        status <= ST_BAD_FAVOR;
      end else if (cmd_r == CMD_CREATE) begin
        if (found) created_id <= nid_r;
        else       status     <= ST_TABLE_FULL;
      end else if (!found) begin
        status <= ST_NO_LOCK;
      end else if (cmd_r == CMD_ACQUIRE) begin
        if (!held[sel])               granted_now <= 1'b1;
        else if (count[sel] == QD_C)  status      <= ST_QUEUE_FULL;
      end else if (cmd_r == CMD_RELEASE) begin
        if (!held[sel] || (owner[sel] != req_r)) status <= ST_NOT_OWNER;
      end else begin
        if (held[sel] || (count[sel] != '0)) status <= ST_BUSY;
      end
    end else if (cmd.fin) begin
      handoff_valid <= 1'b1;
      handoff_owner <= own;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.finish;
  end

endmodule

FILE: rtl/group_biased_lock_manager.sv
// top level of the group biased lock manager
//
//  channel   handshake        payload
//  command   start / busy     command lock_id new_id favoritism_request
//                             requester requester_group random_percent
//  result    done (1 cycle)   status created_id granted_now handoff_valid
//                             handoff_owner
//
// a transaction is taken when start is high and busy low; its result shows
// on done in the first cycle that busy is low again
// a transaction loads, scans one slot at a time up to the first hit or the
// last slot (a create with bad favoritism skips the scan), then executes; a
// handoff searches the waiters for the releaser's group, shifts the waiters
// ahead of a match up through the waiter memory, else takes the queue head
// reset clears the slot table at once; the waiter memory needs no clearing
// results cannot be stalled by the receiver
module group_biased_lock_manager #(
  parameter int LOCK_SLOTS  = glm_pkg::LOCK_SLOTS_DEF,
  parameter int QUEUE_DEPTH = glm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] lock_id,
  input  logic [31:0] new_id,
  input  logic [6:0]  favoritism_request,
  input  logic [15:0] requester,
  input  logic [7:0]  requester_group,
  input  logic [6:0]  random_percent,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] created_id,
  output logic        granted_now,
  output logic        handoff_valid,
  output logic [15:0] handoff_owner
);
  import glm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  glm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table and waiter storage
  glm_dp #(
    .LOCK_SLOTS  (LOCK_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .command            (command),
    .lock_id            (lock_id),
    .new_id             (new_id),
    .favoritism_request (favoritism_request),
    .requester          (requester),
    .requester_group    (requester_group),
    .random_percent     (random_percent),
    .done               (done),
    .status             (status),
    .created_id         (created_id),
    .granted_now        (granted_now),
    .handoff_valid      (handoff_valid),
    .handoff_owner      (handoff_owner)
  );

endmodule

FILE: rtl/glm_check.sv
// port level checks of the lock manager, bound to the top level
module glm_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [31:0] created_id,
  input logic        granted_now,
  input logic        handoff_valid
);
  import glm_pkg::*;

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepted transaction");

  // a result only appears once the block is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result while busy");

  // a created id is only reported on success
  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    done && (created_id != '0) |-> status == ST_OK)
    else $error("created id with error status");

  // a handoff is a successful release, never an immediate grant
  a_handoff_ok: assert property (@(posedge clk) disable iff (rst)
    done && handoff_valid |-> (status == ST_OK) && !granted_now)
    else $error("bad handoff result");

endmodule

bind group_biased_lock_manager glm_check u_glm_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .created_id    (created_id),
  .granted_now   (granted_now),
  .handoff_valid (handoff_valid)
);
